[sv/learning_automaton_reward_penalty_core_defines.svh]
// assertion macros for the reward-penalty automaton core
`ifndef LEARNING_AUTOMATON_REWARD_PENALTY_CORE_DEFINES_SVH
`define LEARNING_AUTOMATON_REWARD_PENALTY_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LARP_ASSERT_SAME(name, clk_s, rst_n_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("larp: assertion failed");

// next-cycle implication
`define LARP_ASSERT_NEXT(name, clk_s, rst_n_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("larp: assertion failed");

`else

`define LARP_ASSERT_SAME(name, clk_s, rst_n_s, ante, cons)
`define LARP_ASSERT_NEXT(name, clk_s, rst_n_s, ante, cons)

`endif

`endif

[sv/larp_pkg.sv]
`default_nettype none

package larp_pkg;

	localparam int PROB_W     = 17;
	localparam int FRAC_W     = 16;
	localparam int RATE_W     = 16;
	localparam int PROD_W     = 33;
	localparam int OP_W       = 2;
	localparam int NODE_W     = 10;
	localparam int ACT_W      = 4;
	localparam int DRAW_W     = 16;
	localparam int NUM_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DCNT_W     = 5;

	localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIONS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REWARD_RATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_RATE = 2'd2;

	// register reset values
	localparam logic [NUM_W-1:0]  NUM_ACTIONS_RST = 5'd2;
	localparam logic [RATE_W-1:0] RATE_RST        = 16'd6554;

	typedef enum logic [OP_W-1:0] {
		OP_INIT   = 2'd0,
		OP_SELECT = 2'd1,
		OP_UPDATE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_WRAP  = 11'b000_0000_0100,
		S_LOOK  = 11'b000_0000_1000,
		S_DISP  = 11'b000_0001_0000,
		S_DIV   = 11'b000_0010_0000,
		S_INIT  = 11'b000_0100_0000,
		S_SACC  = 11'b000_1000_0000,
		S_UMUL  = 11'b001_0000_0000,
		S_UWR   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

[sv/learning_automaton_reward_penalty_core.sv]
// Table of NODES linear reward-penalty learning automata, one request word at a time.
// Request channel (req_valid/req_stall): op, node, label, draw. A word is taken when
// req_valid is high and req_stall low; req_stall stays high while a word is in work.
// Response channel (rsp_valid/rsp_stall): action, penalized, one word per request,
// held in an output register until taken, so the core accepts its next request
// while a finished response still waits.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): num_actions, reward_rate,
// penalty_rate; cfg_ready is always high, write only while the core is idle.
// With n the clamped action count: a node wraps in W restoring steps (0 when
// NODES >= 1024, else up to 10); a select walks k entries (k <= n); init writes
// n entries and an update rewrites n entries. Init and penalty updates first run
// the bit-serial divider, which forms 1/n and beta/(n-1). The work is bound by
// the single probability memory port (one entry per cycle) and the shared 17x17
// multiplier. The next request can be taken in the cycle after the response is
// loaded. If the receiver stalls, a finished word waits in the last state until
// the output register frees.
// Reset: config returns to 2 / 6554 / 6554, then a clearing pass over all NODES
// entries zeroes the last-action memory while req_stall stays high.
`default_nettype none

`include "learning_automaton_reward_penalty_core_defines.svh"

module learning_automaton_reward_penalty_core #(
	parameter int NODES       = 1024,
	parameter int MAX_ACTIONS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [larp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [larp_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [larp_pkg::OP_W-1:0]         op,
	input  logic [larp_pkg::NODE_W-1:0]       node,
	input  logic [larp_pkg::ACT_W-1:0]        label,
	input  logic [larp_pkg::DRAW_W-1:0]       draw,

	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [larp_pkg::ACT_W-1:0]        action,
	output logic                              penalized
);

	import larp_pkg::*;

	// node index and per-node row of probabilities
	localparam int NODE_AW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int ACT_AW     = $clog2(MAX_ACTIONS);
	localparam int CNT_W      = $clog2(MAX_ACTIONS + 1);
	localparam int PROB_AW    = NODE_AW + ACT_AW;
	localparam int PROB_DEPTH = NODES * (2 ** ACT_AW);
	localparam int SUM_W      = PROB_W + ACT_AW;

	// node wrap: restoring remainder against NODES << s, s from the top down
	localparam int WRAP_STEPS = (NODES < 1024) ? $clog2(1023 / NODES + 1) : 0;
	localparam logic [NODE_W-1:0] WRAP_BASE = NODE_W'(NODES % 1024);

	// configuration
	logic [NUM_W-1:0]   num_actions_q;
	logic [RATE_W-1:0]  reward_rate_q;
	logic [RATE_W-1:0]  penalty_rate_q;

	// sequencer
	state_t             state_q, state_d;
	logic [NODE_AW-1:0] clr_q;
	logic [3:0]         wstep_q;

	// request word
	op_t                op_q;
	logic [NODE_W-1:0]  node_q;
	logic [ACT_W-1:0]   label_q;
	logic [DRAW_W-1:0]  draw_q;

	// walk state
	logic [CNT_W-1:0]   k_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ACT_W-1:0]   act_q;
	logic               pen_q;

	// bit-serial divider
	logic [CNT_W-1:0]   div_rem_q;
	logic [PROB_W-1:0]  div_quo_q;
	logic [CNT_W-1:0]   div_den_q;
	logic [DCNT_W-1:0]  dcnt_q;

	// shared multiplier stage
	logic [PROD_W-1:0]  prod_q;
	logic [PROB_W-1:0]  addend_q;

	// response register
	logic               rsp_valid_q;
	logic [ACT_W-1:0]   rsp_action_q;
	logic               rsp_pen_q;

	// memories
	logic [PROB_W-1:0]  prob_mem [PROB_DEPTH];
	logic [PROB_W-1:0]  prob_rdata_q;
	logic [ACT_W-1:0]   la_mem [NODES];
	logic [ACT_W-1:0]   la_rdata_q;

	// combinational datapath
	logic [CNT_W-1:0]     n_eff;
	logic [NODE_AW-1:0]   node_idx;
	logic [NODE_W-1:0]    wrap_trial;
	logic [CNT_W-1:0]     k_next;
	logic [CNT_W-1:0]     k_rd;
	logic [PROB_W-1:0]    p_sat;
	logic [SUM_W-1:0]     sum_next;
	logic                 sel_go;
	logic                 hit;
	logic                 reward_hit;
	logic [RATE_W-1:0]    rate;
	logic [PROB_W-1:0]    om_rate;
	logic [PROB_W-1:0]    mul_a;
	logic [PROB_W-1:0]    mul_b;
	logic [2*PROB_W-1:0]  mul_full;
	logic [PROB_W:0]      upd_sum;
	logic [PROB_W-1:0]    upd_sat;
	logic [CNT_W:0]       div_shift;
	logic                 div_ge;
	logic [CNT_W-1:0]     div_rem_next;
	logic                 is_pen;
	logic                 rsp_free;

	logic                 prob_we;
	logic [PROB_AW-1:0]   prob_waddr;
	logic [PROB_AW-1:0]   prob_raddr;
	logic [PROB_W-1:0]    prob_wdata;
	logic                 la_we;
	logic [NODE_AW-1:0]   la_waddr;
	logic [ACT_W-1:0]     la_wdata;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign action    = rsp_action_q;
	assign penalized = rsp_pen_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// action count clamped to 2..MAX_ACTIONS
	always_comb begin
		if (num_actions_q < NUM_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (int'(num_actions_q) > MAX_ACTIONS) begin
			n_eff = CNT_W'(MAX_ACTIONS);
		end else begin
			n_eff = CNT_W'(num_actions_q);
		end
	end

	// node is already below NODES once the wrap steps are done
	assign node_idx   = NODE_AW'(node_q);
	assign wrap_trial = WRAP_BASE << wstep_q;

	assign k_next = k_q + 1'b1;

	// any stored entry above one reads as one
	assign p_sat = (prob_rdata_q > PROB_ONE) ? PROB_ONE : prob_rdata_q;

	// roulette walk: keep going while the running sum is below the draw
	assign sum_next = sum_q + SUM_W'(p_sat);
	assign sel_go   = (sum_next < SUM_W'(draw_q)) && (k_next < n_eff);

	// a stored action at or above n never matches an entry
	assign hit        = (8'(k_q) == 8'(act_q));
	assign reward_hit = !pen_q && hit;
	assign rate       = pen_q ? penalty_rate_q : reward_rate_q;
	assign om_rate    = PROB_ONE - PROB_W'(rate);

	always_comb begin
		if (reward_hit) begin
			mul_a = PROB_W'(reward_rate_q);
			mul_b = PROB_ONE - p_sat;
		end else begin
			mul_a = om_rate;
			mul_b = p_sat;
		end
	end

	assign mul_full = mul_a * mul_b;

	assign upd_sum = (PROB_W + 1)'(prod_q[PROD_W-1:FRAC_W]) + (PROB_W + 1)'(addend_q);
	assign upd_sat = (upd_sum > (PROB_W + 1)'(PROB_ONE)) ? PROB_ONE : PROB_W'(upd_sum);

	// one quotient bit per cycle
	assign div_shift    = {div_rem_q, div_quo_q[PROB_W-1]};
	assign div_ge       = (div_shift >= {1'b0, div_den_q});
	assign div_rem_next = div_ge ? CNT_W'(div_shift - {1'b0, div_den_q})
	                             : div_shift[CNT_W-1:0];

	assign is_pen = (la_rdata_q != label_q);

	// read runs one entry ahead in the accumulate and write-back states
	assign k_rd = ((state_q == S_SACC) || (state_q == S_UWR)) ? k_next : k_q;

	assign prob_raddr = {node_idx, k_rd[ACT_AW-1:0]};
	assign prob_waddr = {node_idx, k_q[ACT_AW-1:0]};
	assign prob_we    = (state_q == S_INIT) || (state_q == S_UWR);
	assign prob_wdata = (state_q == S_INIT) ? div_quo_q : upd_sat;

	assign la_we    = (state_q == S_CLEAR) || ((state_q == S_SACC) && !sel_go);
	assign la_waddr = (state_q == S_CLEAR) ? clr_q : node_idx;
	assign la_wdata = (state_q == S_CLEAR) ? '0 : ACT_W'(k_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == NODE_AW'(NODES - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = (WRAP_STEPS == 0) ? S_LOOK : S_WRAP;
			end
			S_WRAP: begin
				if (wstep_q == '0) state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_DISP;
			end
			S_DISP: begin
				case (op_q)
					OP_INIT:   state_d = S_DIV;
					OP_SELECT: state_d = S_SACC;
					OP_UPDATE: state_d = is_pen ? S_DIV : S_UMUL;
					OP_NOP:    state_d = S_DONE;
					default:   state_d = S_DONE;
				endcase
			end
			S_DIV: begin
				if (dcnt_q == DCNT_W'(PROB_W - 1)) begin
					state_d = (op_q == OP_INIT) ? S_INIT : S_UMUL;
				end
			end
			S_INIT: begin
				if (!(k_next < n_eff)) state_d = S_DONE;
			end
			S_SACC: begin
				if (!sel_go) state_d = S_DONE;
			end
			S_UMUL: begin
				state_d = S_UWR;
			end
			S_UWR: begin
				state_d = (k_next < n_eff) ? S_UMUL : S_DONE;
			end
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			rsp_valid_q    <= 1'b0;
			num_actions_q  <= NUM_ACTIONS_RST;
			reward_rate_q  <= RATE_RST;
			penalty_rate_q <= RATE_RST;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NUM_ACTIONS:  num_actions_q  <= cfg_data[NUM_W-1:0];
					CFG_REWARD_RATE:  reward_rate_q  <= cfg_data[RATE_W-1:0];
					CFG_PENALTY_RATE: penalty_rate_q <= cfg_data[RATE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= op_t'(op);
				node_q  <= node;
				label_q <= label;
				draw_q  <= draw;
				wstep_q <= 4'(WRAP_STEPS - 1);
			end
			S_WRAP: begin
				if (node_q >= wrap_trial) node_q <= node_q - wrap_trial;
				wstep_q <= wstep_q - 1'b1;
			end
			S_LOOK: begin
				k_q <= '0;
			end
			S_DISP: begin
				act_q     <= la_rdata_q;
				pen_q     <= (op_q == OP_UPDATE) && is_pen;
				sum_q     <= '0;
				div_rem_q <= '0;
				dcnt_q    <= '0;
				if (op_q == OP_INIT) begin
					div_quo_q <= PROB_ONE;
					div_den_q <= n_eff;
				end else begin
					div_quo_q <= PROB_W'(penalty_rate_q);
					div_den_q <= n_eff - 1'b1;
				end
			end
			S_DIV: begin
				div_rem_q <= div_rem_next;
				div_quo_q <= {div_quo_q[PROB_W-2:0], div_ge};
				dcnt_q    <= dcnt_q + 1'b1;
			end
			S_INIT: begin
				k_q <= k_next;
			end
			S_SACC: begin
				sum_q <= sum_next;
				k_q   <= k_next;
				if (!sel_go) act_q <= ACT_W'(k_q);
			end
			S_UMUL: begin
				prod_q <= mul_full[PROD_W-1:0];
				if (reward_hit) begin
					addend_q <= p_sat;
				end else if (pen_q && !hit) begin
					addend_q <= div_quo_q;
				end else begin
					addend_q <= '0;
				end
			end
			S_UWR: begin
				k_q <= k_next;
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_action_q <= act_q;
					rsp_pen_q    <= pen_q;
				end
			end
			default: ;
		endcase
	end

	// probability table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (prob_we) prob_mem[prob_waddr] <= prob_wdata;
		prob_rdata_q <= prob_mem[prob_raddr];
	end

	// last chosen action per node
	always_ff @(posedge clk) begin
		if (la_we) la_mem[la_waddr] <= la_wdata;
		la_rdata_q <= la_mem[node_idx];
	end

	// clearing pass keeps both channels quiet
	`LARP_ASSERT_SAME(a_clear_quiet, clk, arst_n, state_q == S_CLEAR, !rsp_valid_q && req_stall)
	// an accepted word always starts the wrap or lookup
	`LARP_ASSERT_NEXT(a_accept_starts, clk, arst_n, req_valid && !req_stall, state_q == S_WRAP || state_q == S_LOOK)
	// entry walks stay inside the clamped action count
	`LARP_ASSERT_SAME(a_walk_in_range, clk, arst_n, state_q == S_UMUL || state_q == S_SACC || state_q == S_INIT, k_q < n_eff)
	// a response only appears after the finishing state
	`LARP_ASSERT_SAME(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q), $past(state_q) == S_DONE)

endmodule

`default_nettype wire
